// ===== hw/rtl/gts_pkg.sv =====
package gts_pkg;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int SP_W        = 31;
  localparam int DIMS_W      = 18;
  localparam int IDX_W       = 15;
  localparam int NODE_DEPTH  = 32768;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 136;
  localparam int DEN_W       = 33;

  // parameter defaults
  localparam int MAX_DIM_DEF   = 32;
  localparam int FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [SP_W-1:0]   SPACING_RST = 31'd65536;
  localparam logic [DIMS_W-1:0] DIMS_RST    = 18'd133250;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SP_X  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SP_Y  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SP_Z  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIMS  = 3'd6;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_DIST = 2'd1,
    REQ_GRAD = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // result kinds
  localparam logic KIND_DIST = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

endpackage

// ===== hw/rtl/gts_ram.sv =====
module gts_ram #(
  parameter int WIDTH = gts_pkg::DATA_W,
  parameter int DEPTH = gts_pkg::NODE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/gts_div.sv =====
// restoring divider, one quotient bit per cycle
module gts_div #(
  parameter int NUM_W = 55,
  parameter int DEN_W = gts_pkg::DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hw/rtl/grid_trilinear_sampler_top.sv =====
// A load writes the node store on acceptance and gives no result. A distance item on a
// valid grid divides each axis with a positive offset in the shared divider, does eight
// node reads and seven blends, then sends its result. A gradient item takes up to six
// samples and three divides. Throughput: one item at a time, in_tready only while idle;
// a stalled result holds the block in done.
// Reset (synchronous, rst_n low) clears control and config; the node store is not.
module grid_trilinear_sampler_top #(
  parameter int MAX_DIM   = gts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = gts_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // node_index, node_value, point_x, point_y, point_z
  input  logic [gts_pkg::IN_TDATA_W-1:0]       in_tdata,
  // req_type
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // distance, grad_x, grad_y, grad_z, grid_ok
  output logic [gts_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // result_kind
  output logic [0:0]                           out_tuser,
  input  logic                                 cfg_we,
  input  logic [gts_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [gts_pkg::DATA_W-1:0]           cfg_wdata
);

  localparam int F     = FRAC_BITS;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int PW    = 33 + CNT_W;
  localparam int DW    = PW + F;
  localparam int UW    = CNT_W + F;
  localparam int IW    = gts_pkg::IDX_W;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_GHI  = 16'h0002, S_GCL  = 16'h0004, S_GPT  = 16'h0008,
    S_GDEN = 16'h0010, S_AXIS = 16'h0020, S_DIVW = 16'h0040, S_ADR0 = 16'h0080,
    S_ADR1 = 16'h0100, S_RDW  = 16'h0200, S_LDIF = 16'h0400, S_LMUL = 16'h0800,
    S_LADD = 16'h1000, S_SEND = 16'h2000, S_GDIV = 16'h4000, S_DONE = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic signed [31:0] org_r [3];
  logic [30:0]        sp_r [3];
  logic [17:0]        dims_r;

  // per-item state
  logic signed [PW-1:0] q_r [3];
  logic signed [PW-1:0] c_r [3];
  logic signed [PW-1:0] hi_r [3];
  logic signed [PW-1:0] mn_r, pl_r;
  logic [UW-1:0]        u_r [3];
  logic [30+CNT_W:0]    hm_r;
  logic [32:0]          den_r;
  logic [IW-1:0]        jk_r;
  logic signed [31:0]   opa_r, opb_r, la_r, sres_r, spl_r, dist_r;
  logic signed [31:0]   lv_r [6];
  logic signed [31:0]   grad_r [3];
  logic signed [32:0]   dif_r;
  logic [F-1:0]         lt_r;
  logic signed [33+F:0] prod_r;
  logic [1:0]           ax_r, gax_r;
  logic [2:0]           lop_r;
  logic                 rdsel_r, minus_r, is_grad_r, ok_r, neg_r;
  logic                 out_valid_r;
  logic [gts_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                 out_kind_r;

  // grid geometry
  logic [CNT_W-1:0] n_c [3];
  logic [6:0]       raw_c [3];
  logic             ok_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      raw_c[a] = {1'b0, dims_r[6*a +: 6]} + 7'd1;
      n_c[a]   = (raw_c[a] > 7'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(raw_c[a]);
    end
  end

  assign ok_c = (sp_r[0] != '0) && (sp_r[1] != '0) && (sp_r[2] != '0) &&
                (dims_r[5:0] != '0) && (dims_r[11:6] != '0) && (dims_r[17:12] != '0);

  // input handshake
  logic          in_acc;
  gts_pkg::req_t req;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign req       = gts_pkg::req_t'(in_tuser);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      sp_r[0]  <= gts_pkg::SPACING_RST;
      sp_r[1]  <= gts_pkg::SPACING_RST;
      sp_r[2]  <= gts_pkg::SPACING_RST;
      dims_r   <= gts_pkg::DIMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gts_pkg::CFG_ORG_X: org_r[0] <= cfg_wdata;
        gts_pkg::CFG_ORG_Y: org_r[1] <= cfg_wdata;
        gts_pkg::CFG_ORG_Z: org_r[2] <= cfg_wdata;
        gts_pkg::CFG_SP_X:  sp_r[0]  <= cfg_wdata[30:0];
        gts_pkg::CFG_SP_Y:  sp_r[1]  <= cfg_wdata[30:0];
        gts_pkg::CFG_SP_Z:  sp_r[2]  <= cfg_wdata[30:0];
        gts_pkg::CFG_DIMS:  dims_r   <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  // corner selection from the mapped coordinates
  logic [CNT_W-1:0] lo_i [3];
  logic [CNT_W-1:0] up_i [3];
  logic [CNT_W:0]   inc_i [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_i[a]  = u_r[a][UW-1:F];
      inc_i[a] = {1'b0, lo_i[a]} + (CNT_W+1)'(1);
      up_i[a]  = (inc_i[a] < {1'b0, n_c[a]}) ? CNT_W'(inc_i[a]) : n_c[a] - CNT_W'(1);
    end
  end

  logic [CNT_W-1:0] i_sel, j_sel, k_sel;
  logic [IW-1:0]    jk_c, raddr_c;

  assign i_sel   = rdsel_r  ? up_i[0] : lo_i[0];
  assign j_sel   = lop_r[0] ? up_i[1] : lo_i[1];
  assign k_sel   = lop_r[1] ? up_i[2] : lo_i[2];
  assign jk_c    = IW'(j_sel) + IW'(n_c[1]) * IW'(k_sel);
  assign raddr_c = IW'(i_sel) + IW'(n_c[0]) * jk_r;

  // node store
  logic [31:0] ram_rdata;
  logic        ram_we, ram_re;

  assign ram_we = in_acc && (req == gts_pkg::REQ_LOAD);
  assign ram_re = (state_r == S_ADR1);

  gts_ram #(
    .WIDTH(gts_pkg::DATA_W),
    .DEPTH(gts_pkg::NODE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_tdata[IW-1:0]),
    .wdata(in_tdata[IW +: 32]),
    .re   (ram_re),
    .raddr(raddr_c),
    .rdata(ram_rdata)
  );

  // axis offset to grid units
  logic signed [PW:0] d_ax;
  logic               d_pos;
  logic [UW-1:0]      top_c;

  assign d_ax  = (PW+1)'(q_r[ax_r]) - (PW+1)'(org_r[ax_r]);
  assign d_pos = !d_ax[PW] && (d_ax != '0);
  assign top_c = {n_c[ax_r] - CNT_W'(1), {F{1'b0}}};

  // derivative difference
  logic signed [32:0] ds_c;
  logic [32:0]        mag_c;

  assign ds_c  = 33'(spl_r) - 33'(sres_r);
  assign mag_c = ds_c[32] ? 33'(-ds_c) : 33'(ds_c);

  // shared divider
  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_quot;
  logic [32:0]   div_den;

  always_comb begin
    div_start = 1'b0;
    div_num   = {d_ax[PW-1:0], {F{1'b0}}};
    div_den   = {2'b00, sp_r[ax_r]};
    if (state_r == S_AXIS && d_pos) begin
      div_start = 1'b1;
    end else if (state_r == S_SEND && is_grad_r && minus_r) begin
      div_start = 1'b1;
      div_num   = DW'({mag_c, {F{1'b0}}});
      div_den   = den_r;
    end
  end

  gts_div #(
    .NUM_W(DW),
    .DEN_W(gts_pkg::DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // gradient box and step points
  logic signed [PW-1:0] hi_c, h_g, lo_g, cm_c, cp_c, dd_c;

  assign hi_c = PW'(org_r[ax_r]) + $signed(PW'(hm_r));
  assign h_g  = $signed(PW'(sp_r[gax_r]));
  assign lo_g = PW'(org_r[gax_r]);
  assign cm_c = c_r[gax_r] - h_g;
  assign cp_c = c_r[gax_r] + h_g;
  assign dd_c = pl_r - mn_r;

  // lerp operand select
  logic signed [31:0]   la_c, lb_c;
  logic [F-1:0]         lt_c;
  logic signed [33+F:0] lsum_c;

  always_comb begin
    la_c = opa_r;
    lb_c = opb_r;
    lt_c = u_r[0][F-1:0];
    if (lop_r == 3'd4) begin
      la_c = lv_r[0];
      lb_c = lv_r[1];
      lt_c = u_r[1][F-1:0];
    end else if (lop_r == 3'd5) begin
      la_c = lv_r[2];
      lb_c = lv_r[3];
      lt_c = u_r[1][F-1:0];
    end else if (lop_r == 3'd6) begin
      la_c = lv_r[4];
      lb_c = lv_r[5];
      lt_c = u_r[2][F-1:0];
    end
  end

  assign lsum_c = (34+F)'(la_r) + (prod_r >>> F);

  // saturated signed quotient
  logic signed [31:0] gq_c;

  always_comb begin
    if (neg_r) begin
      gq_c = (div_quot > DW'(33'h080000000)) ? 32'sh80000000 : 32'(32'd0 - div_quot[31:0]);
    end else begin
      gq_c = (div_quot > DW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : div_quot[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && req == gts_pkg::REQ_DIST) begin
          state_nxt = ok_c ? S_AXIS : S_DONE;
        end else if (in_acc && req == gts_pkg::REQ_GRAD) begin
          state_nxt = ok_c ? S_GHI : S_DONE;
        end
      end
      S_GHI:  state_nxt = S_GCL;
      S_GCL:  state_nxt = (ax_r == 2'd2) ? S_GPT : S_GHI;
      S_GPT:  state_nxt = S_GDEN;
      S_GDEN: begin
        if (dd_c > 0)             state_nxt = S_AXIS;
        else if (gax_r == 2'd2)   state_nxt = S_DONE;
        else                      state_nxt = S_GPT;
      end
      S_AXIS: begin
        if (d_pos)                state_nxt = S_DIVW;
        else if (ax_r == 2'd2)    state_nxt = S_ADR0;
      end
      S_DIVW: begin
        if (div_done) state_nxt = (ax_r == 2'd2) ? S_ADR0 : S_AXIS;
      end
      S_ADR0: state_nxt = S_ADR1;
      S_ADR1: state_nxt = S_RDW;
      S_RDW:  state_nxt = rdsel_r ? S_LDIF : S_ADR0;
      S_LDIF: state_nxt = S_LMUL;
      S_LMUL: state_nxt = S_LADD;
      S_LADD: begin
        if (lop_r < 3'd3)        state_nxt = S_ADR0;
        else if (lop_r < 3'd6)   state_nxt = S_LDIF;
        else                     state_nxt = S_SEND;
      end
      S_SEND: begin
        if (!is_grad_r)          state_nxt = S_DONE;
        else if (!minus_r)       state_nxt = S_AXIS;
        else                     state_nxt = S_GDIV;
      end
      S_GDIV: begin
        if (div_done) state_nxt = (gax_r == 2'd2) ? S_DONE : S_GPT;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (req == gts_pkg::REQ_DIST || req == gts_pkg::REQ_GRAD)) begin
          is_grad_r <= (req == gts_pkg::REQ_GRAD);
          ok_r      <= ok_c;
          dist_r    <= '0;
          grad_r[0] <= '0;
          grad_r[1] <= '0;
          grad_r[2] <= '0;
          ax_r      <= '0;
          gax_r     <= '0;
          minus_r   <= 1'b0;
          lop_r     <= '0;
          rdsel_r   <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            q_r[a] <= PW'($signed(in_tdata[IW+32+32*a +: 32]));
            c_r[a] <= PW'($signed(in_tdata[IW+32+32*a +: 32]));
          end
        end
      end
      S_GHI: hm_r <= (31+CNT_W)'(sp_r[ax_r]) * (31+CNT_W)'(n_c[ax_r] - CNT_W'(1));
      S_GCL: begin
        hi_r[ax_r] <= hi_c;
        if (c_r[ax_r] < PW'(org_r[ax_r]))  c_r[ax_r] <= PW'(org_r[ax_r]);
        else if (c_r[ax_r] > hi_c)         c_r[ax_r] <= hi_c;
        ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
      end
      S_GPT: begin
        mn_r <= (cm_c < lo_g) ? lo_g : cm_c;
        pl_r <= (cp_c > hi_r[gax_r]) ? hi_r[gax_r] : cp_c;
      end
      S_GDEN: begin
        den_r <= dd_c[32:0];
        if (dd_c > 0) begin
          for (int a = 0; a < 3; a++) begin
            q_r[a] <= (gax_r == 2'(a)) ? pl_r : c_r[a];
          end
          minus_r <= 1'b0;
          ax_r    <= '0;
          lop_r   <= '0;
          rdsel_r <= 1'b0;
        end else begin
          gax_r <= gax_r + 2'd1;
        end
      end
      S_AXIS: begin
        if (!d_pos) begin
          u_r[ax_r] <= '0;
          ax_r      <= ax_r + 2'd1;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          u_r[ax_r] <= (div_quot > DW'(top_c)) ? top_c : div_quot[UW-1:0];
          ax_r      <= ax_r + 2'd1;
        end
      end
      S_ADR0: jk_r <= jk_c;
      S_ADR1: ;
      S_RDW: begin
        if (rdsel_r) begin
          opb_r <= ram_rdata;
        end else begin
          opa_r   <= ram_rdata;
          rdsel_r <= 1'b1;
        end
      end
      S_LDIF: begin
        dif_r <= 33'(lb_c) - 33'(la_c);
        la_r  <= la_c;
        lt_r  <= lt_c;
      end
      S_LMUL: prod_r <= dif_r * $signed({1'b0, lt_r});
      S_LADD: begin
        if (lop_r == 3'd6) begin
          sres_r <= lsum_c[31:0];
        end else begin
          lv_r[lop_r] <= lsum_c[31:0];
        end
        lop_r   <= lop_r + 3'd1;
        rdsel_r <= 1'b0;
      end
      S_SEND: begin
        if (!is_grad_r) begin
          dist_r <= sres_r;
        end else if (!minus_r) begin
          spl_r       <= sres_r;
          minus_r     <= 1'b1;
          q_r[gax_r]  <= mn_r;
          ax_r        <= '0;
          lop_r       <= '0;
          rdsel_r     <= 1'b0;
        end else begin
          neg_r <= ds_c[32];
        end
      end
      S_GDIV: begin
        if (div_done) begin
          grad_r[gax_r] <= gq_c;
          gax_r         <= gax_r + 2'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {7'd0, ok_r, grad_r[2], grad_r[1], grad_r[0], dist_r};
          out_kind_r <= is_grad_r ? gts_pkg::KIND_GRAD : gts_pkg::KIND_DIST;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

endmodule

// ===== hw/rtl/gts_chk.sv =====
module gts_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [1:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a load never raises a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == gts_pkg::REQ_LOAD && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result");

  // bad grid gives all zero values
  a_bad_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[128] |-> out_tdata[127:0] == '0)
    else $error("nonzero value on invalid grid");

  // distance item carries no gradient, gradient item no distance
  a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == gts_pkg::KIND_DIST && out_tdata[127:32] == '0) ||
                   (out_tuser[0] == gts_pkg::KIND_GRAD && out_tdata[31:0] == '0))
    else $error("field not zero for result kind");

endmodule

bind grid_trilinear_sampler_top gts_chk u_gts_chk (.*);

// ===== test/grid_trilinear_sampler_top_tb.sv =====
module grid_trilinear_sampler_top_tb;
  import gts_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_ITEMS = 90;
  localparam int NUM_PHASES  = 8;

  // one expected or observed result item
  typedef struct {
    bit        kind;
    bit [31:0] dval;
    bit [31:0] gx;
    bit [31:0] gy;
    bit [31:0] gz;
    bit        ok;
  } grid_result_t;

  // grid sampler prediction and result queue
  class grid_scoreboard;
    bit [31:0] org[3];
    bit [30:0] spc[3];
    bit [17:0] dims;
    bit [31:0] nodes[int];
    int        probe_q[$];
    bit        probing;
    grid_result_t pending_q[$];
    int        errors;
    int        n_dist;
    int        n_grad;

    function void reset_regs();
      foreach (org[a]) begin
        org[a] = '0;
        spc[a] = SPACING_RST;
      end
      dims = DIMS_RST;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, bit [31:0] data);
      case (addr)
        CFG_ORG_X: org[0] = data;
        CFG_ORG_Y: org[1] = data;
        CFG_ORG_Z: org[2] = data;
        CFG_SP_X:  spc[0] = data[30:0];
        CFG_SP_Y:  spc[1] = data[30:0];
        CFG_SP_Z:  spc[2] = data[30:0];
        CFG_DIMS:  dims   = data[17:0];
        default: ;
      endcase
    endfunction

    function longint n_axis(int a);
      longint c;
      c = ((dims >> (6 * a)) & 63) + 1;
      return (c > MAX_DIM_DEF) ? MAX_DIM_DEF : c;
    endfunction

    function bit grid_ok();
      return spc[0] != 0 && spc[1] != 0 && spc[2] != 0 &&
             n_axis(0) >= 2 && n_axis(1) >= 2 && n_axis(2) >= 2;
    endfunction

    // world coordinate to grid units, clamped to the box
    function longint axis_units(longint p, int a);
      longint d, u, top, sp, n;
      sp = spc[a];
      n  = n_axis(a);
      if (sp == 0 || n <= 1) return 0;
      d = p - longint'($signed(org[a]));
      if (d <= 0) return 0;
      u   = (d <<< FRAC_BITS_DEF) / sp;
      top = (n - 1) <<< FRAC_BITS_DEF;
      return (u > top) ? top : u;
    endfunction

    function longint node_val(longint i, longint j, longint k, longint nx, longint ny);
      int idx;
      idx = int'((i + nx * (j + ny * k)) & (NODE_DEPTH - 1));
      if (probing) probe_q.push_back(idx);
      return nodes.exists(idx) ? longint'($signed(nodes[idx])) : 0;
    endfunction

    // floor-rounded linear blend
    function longint blend(longint lo_v, longint hi_v, longint t);
      return lo_v + (((hi_v - lo_v) * t) >>> FRAC_BITS_DEF);
    endfunction

    function longint trilinear(longint p[3]);
      longint nx, ny, nz, ux, uy, uz, tx, ty, tz;
      longint i0, j0, k0, i1, j1, k1, c00, c10, c01, c11, c0, c1;
      if (!grid_ok()) return 0;
      nx = n_axis(0); ny = n_axis(1); nz = n_axis(2);
      ux = axis_units(p[0], 0);
      uy = axis_units(p[1], 1);
      uz = axis_units(p[2], 2);
      i0 = ux >>> FRAC_BITS_DEF; tx = ux & 16'hFFFF;
      j0 = uy >>> FRAC_BITS_DEF; ty = uy & 16'hFFFF;
      k0 = uz >>> FRAC_BITS_DEF; tz = uz & 16'hFFFF;
      i1 = (i0 + 1 < nx) ? i0 + 1 : nx - 1;
      j1 = (j0 + 1 < ny) ? j0 + 1 : ny - 1;
      k1 = (k0 + 1 < nz) ? k0 + 1 : nz - 1;
      c00 = blend(node_val(i0, j0, k0, nx, ny), node_val(i1, j0, k0, nx, ny), tx);
      c10 = blend(node_val(i0, j1, k0, nx, ny), node_val(i1, j1, k0, nx, ny), tx);
      c01 = blend(node_val(i0, j0, k1, nx, ny), node_val(i1, j0, k1, nx, ny), tx);
      c11 = blend(node_val(i0, j1, k1, nx, ny), node_val(i1, j1, k1, nx, ny), tx);
      c0  = blend(c00, c10, ty);
      c1  = blend(c01, c11, ty);
      return blend(c0, c1, tz);
    endfunction

    function grid_result_t predict(req_t req, longint p[3]);
      grid_result_t r;
      longint c[3], mn[3], pl[3], lo, hi, h, denom, ds, g;
      r.kind = (req == REQ_GRAD) ? KIND_GRAD : KIND_DIST;
      r.ok   = grid_ok();
      r.dval = '0; r.gx = '0; r.gy = '0; r.gz = '0;
      if (req == REQ_DIST) begin
        r.dval = 32'(trilinear(p));
      end else if (r.ok) begin
        // clamp the point into the box
        for (int a = 0; a < 3; a++) begin
          lo = $signed(org[a]);
          hi = lo + longint'(spc[a]) * (n_axis(a) - 1);
          c[a] = (p[a] < lo) ? lo : ((p[a] > hi) ? hi : p[a]);
        end
        // central difference, steps shortened at box edges
        for (int a = 0; a < 3; a++) begin
          h  = spc[a];
          lo = $signed(org[a]);
          hi = lo + h * (n_axis(a) - 1);
          mn = c;
          pl = c;
          mn[a] = (c[a] - h < lo) ? lo : c[a] - h;
          pl[a] = (c[a] + h > hi) ? hi : c[a] + h;
          denom = pl[a] - mn[a];
          if (denom > 0) begin
            ds = trilinear(pl) - trilinear(mn);
            g  = (ds * (longint'(1) <<< FRAC_BITS_DEF)) / denom;
            if (g > 64'sh7FFFFFFF) g = 64'sh7FFFFFFF;
            if (g < -64'sh80000000) g = -64'sh80000000;
            if (a == 0) r.gx = 32'(g);
            else if (a == 1) r.gy = 32'(g);
            else r.gz = 32'(g);
          end
        end
      end
      return r;
    endfunction

    function void note_input(req_t req, bit [14:0] idx, bit [31:0] val, longint p[3]);
      case (req)
        REQ_LOAD: nodes[int'(idx)] = val;
        REQ_DIST, REQ_GRAD: pending_q.push_back(predict(req, p));
        default: ;
      endcase
    endfunction

    function void cmp(string name, bit [31:0] e, bit [31:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check(bit [OUT_TDATA_W-1:0] data, bit kind);
      grid_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.kind == KIND_GRAD) n_grad++;
      else n_dist++;
      cmp("result_kind", 32'(e.kind), 32'(kind));
      cmp("distance", e.dval, data[31:0]);
      cmp("grad_x", e.gx, data[63:32]);
      cmp("grad_y", e.gy, data[95:64]);
      cmp("grad_z", e.gz, data[127:96]);
      cmp("grid_ok", 32'(e.ok), 32'(data[128]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;

  grid_scoreboard sb = new();
  int in_idle_pct  = 20;
  int out_idle_pct = 54;
  int phase_no     = 0;
  int items_sent   = 0;
  int phase_items  = 0;
  int hold_left    = 0;
  bit hold_done    = 0;
  int quiet        = 0;

  grid_trilinear_sampler_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check, random stalls, one long hold-off
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser[0]);
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && phase_no == 1 && phase_items >= 20) begin
      hold_left  <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("grid_trilinear_sampler_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(req_t req, bit [14:0] idx, bit [31:0] val,
                           bit [31:0] px, bit [31:0] py, bit [31:0] pz);
    longint p[3];
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, pz, py, px, val, idx};
    do @(posedge clk); while (!in_tready);
    p[0] = $signed(px); p[1] = $signed(py); p[2] = $signed(pz);
    sb.note_input(req, idx, val, p);
    items_sent++;
    phase_items++;
  endtask

  // load every node the request will read that was never written, then send it
  task automatic send_request(req_t req, bit [31:0] px, bit [31:0] py, bit [31:0] pz);
    longint p[3];
    grid_result_t dummy;
    int touched[$];
    p[0] = $signed(px); p[1] = $signed(py); p[2] = $signed(pz);
    sb.probe_q.delete();
    sb.probing = 1'b1;
    dummy = sb.predict(req, p);
    sb.probing = 1'b0;
    touched = sb.probe_q;
    foreach (touched[n])
      if (!sb.nodes.exists(touched[n]))
        send_item(REQ_LOAD, 15'(touched[n]), $urandom(), $urandom(), $urandom(), $urandom());
    send_item(req, 15'($urandom()), $urandom(), px, py, pz);
  endtask

  function automatic bit [31:0] pick_coord(int a);
    longint base, sp, n, span;
    base = $signed(sb.org[a]);
    sp   = sb.spc[a];
    n    = sb.n_axis(a);
    span = sp * (n + 1);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      3: return 32'(base + sp * $urandom_range(0, 31));
      default: return 32'(base - sp + ((span * $urandom_range(0, 65535)) >>> 16));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_request(REQ_DIST, pick_coord(0), pick_coord(1), pick_coord(2));
    else if (r < 70)
      send_request(REQ_GRAD, pick_coord(0), pick_coord(1), pick_coord(2));
    else if (r < 94)
      send_item(REQ_LOAD, 15'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    else
      send_item(REQ_NONE, 15'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic load_phase(int ph);
    bit [31:0] ox, oy, oz, sx, sy, sz, dm;
    ox = 0; oy = 0; oz = 0;
    sx = 32'h10000; sy = 32'h10000; sz = 32'h10000;
    dm = {14'd0, 6'($urandom_range(1, 3)), 6'($urandom_range(1, 3)), 6'($urandom_range(1, 3))};
    case (ph)
      1: dm = {14'd0, 6'd3, 6'd1, 6'd2};
      2: begin
        ox = -32'sd360448; oy = 32'h0003_8000; oz = -32'sd65536;
        sx = 32'hC000; sy = 32'h2_4000; sz = 32'h1_8000;
      end
      3: begin
        ox = 32'h8000_0000; oy = 32'h8000_0000; oz = 32'h8000_0000;
        sx = 32'h7FFF_FFFF; sy = 32'h7FFF_FFFF; sz = 32'h7FFF_FFFF;
        dm = 32'h3FFFF;
      end
      4: begin
        ox = 32'h7FFF_FFFF; oy = 32'h7FFF_FFFF; oz = 32'h7FFF_FFFF;
        sx = 1; sy = 1; sz = 1;
        dm = {14'd0, 6'd1, 6'd1, 6'd1};
      end
      5: sy = 0;
      6: dm = 0;
      7: begin
        ox = $urandom(); oy = $urandom(); oz = $urandom();
        sx = $urandom_range(1, 32'h40000); sy = $urandom_range(1, 32'h40000);
        sz = $urandom_range(1, 32'h40000);
      end
      default: ;
    endcase
    write_cfg(CFG_ORG_X, ox);
    write_cfg(CFG_ORG_Y, oy);
    write_cfg(CFG_ORG_Z, oz);
    write_cfg(CFG_SP_X, sx);
    write_cfg(CFG_SP_Y, sy);
    write_cfg(CFG_SP_Z, sz);
    write_cfg(CFG_DIMS, dm);
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb.reset_regs();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at the reset configuration
    send_item(REQ_LOAD, 15'd0, 32'h8000_0000, 0, 0, 0);
    send_item(REQ_LOAD, 15'h7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_NONE, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_DIST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(REQ_DIST, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(REQ_GRAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(REQ_GRAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(REQ_DIST, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000);
    send_request(REQ_GRAD, 32'h0, 32'h0, 32'h0);
    send_request(REQ_GRAD, 32'h0002_0000, 32'h001F_0000, 32'h001F_0000);
    send_request(REQ_DIST, 32'h0000_0001, 32'h001E_FFFF, 32'h0010_8000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
        load_phase(ph);
      end
      phase_no     = ph;
      phase_items  = 0;
      in_idle_pct  = (ph < 3) ? 20 : ((ph < 6) ? 54 : 0);
      out_idle_pct = (ph < 3) ? 54 : ((ph < 6) ? 20 : 0);
      while (phase_items < PHASE_ITEMS) random_item();
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Sent %0d items over %0d grid setups; checked %0d distance and %0d gradient results.",
             items_sent, NUM_PHASES, sb.n_dist, sb.n_grad);
    if (sb.errors == 0) begin
      $display("grid_trilinear_sampler_top test passed");
    end else begin
      $display("grid_trilinear_sampler_top test failed");
    end
    $finish;
  end
endmodule
